### hw/rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`default_nettype none
package mexp_pkg;
    localparam int WORD_WIDTH = 64;
    localparam int CNT_W      = $clog2(WORD_WIDTH);
    localparam int MOD_W      = WORD_WIDTH + 1;

    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_CHK,
        ST_MACC,
        ST_SQR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                    start;
        logic [WORD_WIDTH-1:0]   a;
        logic [WORD_WIDTH-1:0]   b;
        logic [MOD_W-1:0]        m;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic [WORD_WIDTH-1:0]   result;
    } t_mul_rsp;
endpackage
`default_nettype wire

### hw/rtl/mexp_cell.sv
// One bit cell of the multiplier operand shift chain.
`default_nettype none
module mexp_cell (
    input  wire logic i_clk,
    input  wire logic i_load,
    input  wire logic i_load_bit,
    input  wire logic i_shift,
    input  wire logic i_prev_bit,
    output logic      o_bit
);
    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bit <= i_load_bit;
        end else if (i_shift) begin
            r_bit <= i_prev_bit;
        end
    end

    assign o_bit = r_bit;
endmodule
`default_nettype wire

### hw/rtl/mexp_mulred.sv
// Bit-serial interleaved multiply-reduce unit fed by a chain of operand bit cells.
`default_nettype none
module mexp_mulred (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mexp_pkg::t_mul_req i_req,
    output mexp_pkg::t_mul_rsp      o_rsp
);
    import mexp_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [WORD_WIDTH-1:0] r_acc;
    logic [WORD_WIDTH-1:0] r_a;
    logic [MOD_W-1:0]      r_m;

    logic [WORD_WIDTH-1:0] chain_bits;
    logic                  cur_bit;
    logic [WORD_WIDTH+1:0] t_sum;
    logic [WORD_WIDTH+2:0] t_sub1;
    logic [WORD_WIDTH+2:0] t_sub2;
    logic [WORD_WIDTH-1:0] n_acc;

    // Multiplier bits leave from the top cell, MSB first.
    for (genvar g = 0; g < WORD_WIDTH; g++) begin : g_cell
        mexp_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (i_req.start),
            .i_load_bit (i_req.b[g]),
            .i_shift    (r_busy),
            .i_prev_bit ((g == 0) ? 1'b0 : chain_bits[(g == 0) ? 0 : g-1]),
            .o_bit      (chain_bits[g])
        );
    end

    assign cur_bit = chain_bits[WORD_WIDTH-1];

    // Double, add, then take off m or 2m; the sum stays below 3m.
    always_comb begin
        t_sum  = {1'b0, r_acc, 1'b0} + {2'b00, (cur_bit ? r_a : {WORD_WIDTH{1'b0}})};
        t_sub1 = {1'b0, t_sum} - {2'b00, r_m};
        t_sub2 = {1'b0, t_sum} - {1'b0, r_m, 1'b0};
        if (!t_sub2[WORD_WIDTH+2]) begin
            n_acc = t_sub2[WORD_WIDTH-1:0];
        end else if (!t_sub1[WORD_WIDTH+2]) begin
            n_acc = t_sub1[WORD_WIDTH-1:0];
        end else begin
            n_acc = t_sum[WORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_WIDTH - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_m   <= i_req.m;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;
endmodule
`default_nettype wire

### hw/rtl/modular_exponentiation_64.sv
// Top level: base ^ exponent mod modulus with an APB register port and stream channels.
// Each base is reduced by the modulus, then the exponent is scanned from its low bit
// with right-to-left square-and-multiply. Every modular product runs through one
// bit-serial multiply-reduce unit whose multiplier bits shift through a row of 64 bit
// cells, one bit a cycle. One item is worked at a time; a finished result waits in
// the output register while the next base is accepted, and the block holds in its last
// state while that register is still full. A zero modulus means 2^64; exponent and
// modulus sit at byte addresses 0 and 8 and must be written while idle; the block
// itself does not enforce this.
`default_nettype none
module modular_exponentiation_64 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] base_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata    // [63:0] power_result
);
    import mexp_pkg::*;

    t_state                r_state, n_state;
    logic [WORD_WIDTH-1:0] r_exp;
    logic [WORD_WIDTH-1:0] r_mod;
    logic [WORD_WIDTH-1:0] r_acc, n_acc;
    logic [WORD_WIDTH-1:0] r_b, n_b;
    logic [WORD_WIDTH-1:0] r_e, n_e;
    logic [WORD_WIDTH-1:0] r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    t_mul_req              mul_req;
    t_mul_rsp              mul_rsp;
    logic [MOD_W-1:0]      mod_eff;
    logic [WORD_WIDTH-1:0] one_mod;
    logic                  cfg_wr;
    logic                  in_acc;
    logic                  out_acc;

    assign mod_eff = {(r_mod == '0), r_mod};
    assign one_mod = (r_mod == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_MODULUS) ? r_mod : r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
            r_mod <= WORD_WIDTH'(2);
        end else if (cfg_wr) begin
            if (paddr[3] == REG_MODULUS) begin
                r_mod <= pwdata;
            end else begin
                r_exp <= pwdata;
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    mexp_mulred u_mulred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_b   <= n_b;
        r_e   <= n_e;
        r_out <= n_out;
    end

    always_comb begin
        n_state       = r_state;
        n_acc         = r_acc;
        n_b           = r_b;
        n_e           = r_e;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !out_acc;
        mul_req.start = 1'b0;
        mul_req.a     = r_b;
        mul_req.b     = r_b;
        mul_req.m     = mod_eff;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // Reduce the base: shift its bits into 2*acc + bit mod m.
                    mul_req.start = 1'b1;
                    mul_req.a     = one_mod;
                    mul_req.b     = s_axis_tdata;
                    n_state       = ST_RED;
                end
            end
            ST_RED: begin
                if (mul_rsp.done) begin
                    n_b     = mul_rsp.result;
                    n_acc   = one_mod;
                    n_e     = r_exp;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_e == '0) begin
                    n_state = ST_DONE;
                end else if (r_e[0]) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_acc;
                    n_state       = ST_MACC;
                end else begin
                    mul_req.start = 1'b1;
                    n_state       = ST_SQR;
                end
            end
            ST_MACC: begin
                if (mul_rsp.done) begin
                    n_acc = mul_rsp.result;
                    // Skip the last square once no higher exponent bits remain.
                    if (r_e[WORD_WIDTH-1:1] == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        n_state       = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (mul_rsp.done) begin
                    n_b     = mul_rsp.result;
                    n_e     = r_e >> 1;
                    n_state = ST_CHK;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == ST_RED || r_state == ST_MACC || r_state == ST_SQR))
        else $error("product finished while no product pending");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> ({1'b0, mul_rsp.result} < mod_eff))
        else $error("product not reduced below modulus");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_RED))
        else $error("accepted base did not start reduction");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK) |-> ({1'b0, r_acc} < mod_eff))
        else $error("running product exceeds modulus");
endmodule
`default_nettype wire

### sim/modular_exponentiation_64_tb.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps
module modular_exponentiation_64_tb;
    import mexp_pkg::*;

    localparam logic [3:0] ADDR_EXPONENT = 4'd0;
    localparam logic [3:0] ADDR_MODULUS  = 4'd8;
    localparam int         STALL_LIMIT   = 40000;
    localparam int         SETTLE_CYC    = 9000;

    typedef struct {
        logic [63:0] exp_v;
        logic [63:0] mod_v;
        logic [63:0] base;
        logic        known;
        logic [63:0] power;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid, s_axis_tready;
    logic [63:0] s_axis_tdata;   // [63:0] base_value
    logic        m_axis_tvalid, m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] power_result

    logic [63:0] cur_exponent, cur_modulus;
    logic [63:0] power_ring[256];
    int          wr_ptr, rd_ptr;
    int          mismatches, results_seen, idle_cycles;
    bit          timed_out;
    bit          rx_enable;

    modular_exponentiation_64 DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // (a * b) mod m with 128-bit products; m == 0 stands for 2^64
    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if (m == 64'd0) return prod[63:0];
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e,
                                            logic [63:0] m);
        logic [63:0] acc, sq;
        if (m == 64'd0) begin
            acc = 64'd1;
            sq  = base;
        end else begin
            acc = 64'd1 % m;
            sq  = base % m;
        end
        for (int i = 0; i < 64; i++) begin
            if (e[i]) acc = mul_mod(acc, sq, m);
            sq = mul_mod(sq, sq, m);
        end
        return acc;
    endfunction

    task automatic apb_write(logic [3:0] addr, logic [63:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_EXPONENT) cur_exponent = data;
        else                       cur_modulus  = data;
    endtask

    // drop valid, hold until all results drained, then let the block settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (wr_ptr != rd_ptr && !timed_out) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // drop valid for the drawn gap, then hold the beat until accepted
    task automatic send_base(logic [63:0] base);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= base;
        do @(posedge i_clk); while (!s_axis_tready && !timed_out);
        power_ring[wr_ptr % 256] = pow_mod(base, cur_exponent, cur_modulus);
        wr_ptr++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // receiver: random stall per beat
    initial begin
        int wait_cyc;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_enable && !m_axis_tready) begin
                if (wait_cyc == 0) m_axis_tready <= 1'b1;
                else wait_cyc--;
            end else if (m_axis_tready && m_axis_tvalid) begin
                wait_cyc = $urandom_range(0, 7);
                if (wait_cyc != 0) m_axis_tready <= 1'b0;
                else               wait_cyc = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (wr_ptr == rd_ptr) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end else begin
                logic [63:0] want;
                want = power_ring[rd_ptr % 256];
                rd_ptr++;
                if (m_axis_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("power_result mismatch: expected %h, got %h",
                                 want, m_axis_tdata);
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[modular_exponentiation_64] ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows[18];
        logic [63:0] exp_set[6];
        logic [63:0] mod_set[6];
        logic [63:0] m;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 0; s_axis_tdata = '0;
        i_rst_n = 0; rx_enable = 0;
        mismatches = 0; results_seen = 0; idle_cycles = 0; timed_out = 0;
        wr_ptr = 0; rd_ptr = 0;
        cur_exponent = 64'd0;
        cur_modulus  = 64'd2;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_enable = 1'b1;

        // exponent, modulus, base, known?, expected
        rows[0]  = '{64'd0, 64'd2, 64'd5, 1'b1, 64'd1};   // after reset
        rows[1]  = '{64'd0, 64'd2, '1, 1'b1, 64'd1};
        rows[2]  = '{64'd0, 64'd1, 64'd9, 1'b1, 64'd0};  // unit modulus
        rows[3]  = '{64'd7, 64'd1, '1, 1'b1, 64'd0};
        rows[4]  = '{64'd0, 64'd0, 64'd3, 1'b1, 64'd1};  // zero modulus
        rows[5]  = '{64'd3, 64'd0, 64'd3, 1'b1, 64'd27};
        rows[6]  = '{'1, 64'd0, 64'd1, 1'b1, 64'd1};
        rows[7]  = '{'1, 64'd0, 64'd0, 1'b1, 64'd0};
        rows[8]  = '{64'd2, 64'd0, '1, 1'b1, 64'd1};
        rows[9]  = '{64'd1, 64'd13, 64'd20, 1'b1, 64'd7};
        rows[10] = '{64'd1, '1, '1, 1'b1, 64'd0};        // base equals modulus
        rows[11] = '{64'd2, '1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'd1};
        rows[12] = '{'1, '1, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd0};
        rows[13] = '{'1, 64'hFFFF_FFFF_FFFF_FFC5, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 64'd0};
        rows[14] = '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'd3, 1'b0, 64'd0};
        rows[15] = '{64'd65537, 64'hC000_0000_0000_0005, '1, 1'b0, 64'd0};
        rows[16] = '{64'd65537, 64'd2, 64'd3, 1'b1, 64'd1};
        rows[17] = '{64'd65537, 64'd2, 64'd0, 1'b1, 64'd0};

        foreach (rows[r]) begin
            if (rows[r].exp_v != cur_exponent || rows[r].mod_v != cur_modulus) begin
                drain();
                apb_write(ADDR_EXPONENT, rows[r].exp_v);
                apb_write(ADDR_MODULUS, rows[r].mod_v);
            end
            send_base(rows[r].base);
            if (rows[r].known && power_ring[(wr_ptr - 1) % 256] !== rows[r].power) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("predictor disagrees on row %0d: %h vs %h",
                             r, power_ring[(wr_ptr - 1) % 256], rows[r].power);
            end
        end

        exp_set = '{64'd0, '1, 64'd65537, 64'd3, 64'h8000_0000_0000_0000, 64'd0};
        mod_set = '{64'd0, 64'd1, '1, 64'd2, 64'h8000_0000_0000_0000, 64'd97};
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            // short exponents mostly; a few full-width ones
            if (ph < 6) apb_write(ADDR_EXPONENT, exp_set[ph]);
            else apb_write(ADDR_EXPONENT, (ph % 2) ? rand64() : 64'($urandom_range(0, 255)));
            m = (ph < 6) ? mod_set[ph] : rand64();
            apb_write(ADDR_MODULUS, m);
            for (int k = 0; k < 8; k++) begin
                case ($urandom_range(0, 3))
                    0:       send_base(64'($urandom_range(0, 3)));
                    1:       send_base(cur_modulus + 64'($urandom_range(0, 2)) - 64'd1);
                    default: send_base(rand64());
                endcase
            end
        end

        drain();
        repeat (SETTLE_CYC / 100) @(posedge i_clk);
        $display("Covered %0d results over reset, zero, unit and full-width settings",
                 results_seen);
        $display("of exponent and modulus, with random stalls on both streams.");
        if (mismatches == 0 && wr_ptr == rd_ptr)
            $display("[modular_exponentiation_64] OK");
        else
            $display("[modular_exponentiation_64] ERROR");
        $finish;
    end
endmodule

### modular_exponentiation_64.f
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_cell.sv
hw/rtl/mexp_mulred.sv
hw/rtl/modular_exponentiation_64.sv
sim/modular_exponentiation_64_tb.sv
